>>> rtl/sba_pkg.sv
package sba_pkg;

    // Operation codes carried in the operation field
    typedef enum logic [2:0] {
        OP_PUSH        = 3'd0,
        OP_POP         = 3'd1,
        OP_RESET_BUF   = 3'd2,
        OP_RESET_STATS = 3'd3,
        OP_RESET_BOTH  = 3'd4
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_POP_BIG  = 2'd2
    } status_t;

    // Sticky error flag bit positions
    localparam int FLAG_NO_SPACE  = 0;
    localparam int FLAG_POP_BIG   = 1;
    localparam int FLAG_LIMIT     = 2;
    localparam int FLAG_OVERFREE  = 3;
    localparam int FLAG_WIDTH     = 4;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOTAL_SPACE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALLOC_LIMIT = 2'd1;

    // Fixed register widths and reset values
    localparam int          LIMIT_WIDTH       = 15;
    localparam logic [31:0] TOTAL_SPACE_RESET = 32'd65536;
    localparam logic [LIMIT_WIDTH-1:0] ALLOC_LIMIT_RESET = 15'd100;

endpackage

>>> rtl/stack_bump_allocator_core.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    operation, alloc_size
// result    out        out_valid/out_ready  status, offset, used_bytes, live_count,
//                                           count_high_peak, count_low_peak, error_flags
// config    in         cfg_we (no wait)     cfg_index, cfg_wdata
//
// One item per cycle sustained while results are taken: each transfer updates the
// allocator state in the same edge and loads the one-deep result register, so the
// next item sees the updated state at once; out_valid rises in the following cycle.
// A stalled result register still accepts a new item in the cycle it drains
// (in_ready = !out_valid || out_ready); otherwise the input side waits.
// Reset clears control state, statistics and restores the config defaults.
module stack_bump_allocator_core #(
    parameter int SPACE_WIDTH = 20,
    parameter int COUNT_WIDTH = 16,
    localparam int CFG_DATA_WIDTH =
        (SPACE_WIDTH > sba_pkg::LIMIT_WIDTH) ? SPACE_WIDTH : sba_pkg::LIMIT_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [sba_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]           cfg_wdata,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          operation,
    input  logic [SPACE_WIDTH-1:0]              alloc_size,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [SPACE_WIDTH-1:0]              offset,
    output logic [SPACE_WIDTH-1:0]              used_bytes,
    output logic signed [COUNT_WIDTH-1:0]       live_count,
    output logic [COUNT_WIDTH-2:0]              count_high_peak,
    output logic signed [COUNT_WIDTH-1:0]       count_low_peak,
    output logic [sba_pkg::FLAG_WIDTH-1:0]      error_flags
);
    import sba_pkg::*;

    localparam int CMP_WIDTH = (COUNT_WIDTH - 1 > LIMIT_WIDTH) ? COUNT_WIDTH - 1 : LIMIT_WIDTH;
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic [SPACE_WIDTH-1:0] TOTAL_RESET = TOTAL_SPACE_RESET[SPACE_WIDTH-1:0];

    // Configuration
    logic [SPACE_WIDTH-1:0] total_space_reg;
    logic [LIMIT_WIDTH-1:0] alloc_limit_reg;

    // Allocator state
    logic [SPACE_WIDTH-1:0]         used_reg, used_next;
    logic signed [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic [COUNT_WIDTH-2:0]         high_peak_reg, high_peak_next;
    logic signed [COUNT_WIDTH-1:0]  low_peak_reg, low_peak_next;
    logic [FLAG_WIDTH-1:0]          flags_reg, flags_next;

    // Result register
    logic                   out_valid_reg;
    status_t                status_reg, status_next;
    logic [SPACE_WIDTH-1:0] offset_reg, offset_next;

    logic in_fire;
    logic push_fits;
    logic pop_fits;
    logic signed [COUNT_WIDTH-1:0] count_inc;
    logic signed [COUNT_WIDTH-1:0] count_dec;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Space left is zero once the offset reaches or passes the buffer size,
    // so only a zero-size push fits then.
    assign push_fits = (used_reg < total_space_reg) ? (alloc_size <= total_space_reg - used_reg)
                                                    : (alloc_size == '0);
    assign pop_fits  = alloc_size <= used_reg;

    // Saturating count steps
    assign count_inc = (count_reg < CNT_MAX) ? count_reg + COUNT_WIDTH'(1) : count_reg;
    assign count_dec = (count_reg > CNT_MIN) ? count_reg - COUNT_WIDTH'(1) : count_reg;

    always_comb
    begin
        used_next      = used_reg;
        count_next     = count_reg;
        high_peak_next = high_peak_reg;
        low_peak_next  = low_peak_reg;
        flags_next     = flags_reg;
        status_next    = ST_OK;
        offset_next    = '0;
        unique case (op_t'(operation))
            OP_PUSH:
            begin
                if (push_fits)
                begin
                    offset_next = used_reg;
                    used_next   = used_reg + alloc_size;
                    count_next  = count_inc;
                    if (count_inc > $signed({1'b0, high_peak_reg}))
                    begin
                        high_peak_next = count_inc[COUNT_WIDTH-2:0];
                    end
                    // limit test sees the peak after this push
                    if (CMP_WIDTH'(high_peak_next) > CMP_WIDTH'(alloc_limit_reg))
                    begin
                        flags_next[FLAG_LIMIT] = 1'b1;
                    end
                end
                else
                begin
                    flags_next[FLAG_NO_SPACE] = 1'b1;
                    status_next = ST_NO_SPACE;
                end
            end
            OP_POP:
            begin
                if (pop_fits)
                begin
                    used_next  = used_reg - alloc_size;
                    count_next = count_dec;
                    if (count_dec < low_peak_reg)
                    begin
                        low_peak_next = count_dec;
                    end
                    if (low_peak_next < 0)
                    begin
                        flags_next[FLAG_OVERFREE] = 1'b1;
                    end
                end
                else
                begin
                    flags_next[FLAG_POP_BIG] = 1'b1;
                    status_next = ST_POP_BIG;
                end
            end
            OP_RESET_BUF:
            begin
                used_next  = '0;
                count_next = '0;
            end
            OP_RESET_STATS:
            begin
                high_peak_next = '0;
                low_peak_next  = '0;
                flags_next     = '0;
            end
            OP_RESET_BOTH:
            begin
                used_next      = '0;
                count_next     = '0;
                high_peak_next = '0;
                low_peak_next  = '0;
                flags_next     = '0;
            end
            default:
            begin
                // unknown codes leave the state alone and report ok
            end
        endcase
    end

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_space_reg <= TOTAL_RESET;
            alloc_limit_reg <= ALLOC_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TOTAL_SPACE)
            begin
                total_space_reg <= cfg_wdata[SPACE_WIDTH-1:0];
            end
            else if (cfg_index == CFG_ALLOC_LIMIT)
            begin
                alloc_limit_reg <= cfg_wdata[LIMIT_WIDTH-1:0];
            end
        end
    end

    // Advance the allocator state on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            count_reg     <= '0;
            high_peak_reg <= '0;
            low_peak_reg  <= '0;
            flags_reg     <= '0;
        end
        else if (in_fire)
        begin
            used_reg      <= used_next;
            count_reg     <= count_next;
            high_peak_reg <= high_peak_next;
            low_peak_reg  <= low_peak_next;
            flags_reg     <= flags_next;
        end
    end

    // Result valid: set on input transfer, drop once the result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: load with the transfer, hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg <= status_next;
            offset_reg <= offset_next;
        end
    end

    // The remaining result fields are the state just written
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign offset          = offset_reg;
    assign used_bytes      = used_reg;
    assign live_count      = count_reg;
    assign count_high_peak = high_peak_reg;
    assign count_low_peak  = low_peak_reg;
    assign error_flags     = flags_reg;

endmodule

>>> rtl/sba_checker.sv
module sba_checker #(
    parameter int SPACE_WIDTH = 20,
    parameter int COUNT_WIDTH = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [1:0]                          status,
    input logic [SPACE_WIDTH-1:0]              offset,
    input logic [SPACE_WIDTH-1:0]              used_bytes,
    input logic signed [COUNT_WIDTH-1:0]       count_low_peak,
    input logic [sba_pkg::FLAG_WIDTH-1:0]      error_flags
);
    import sba_pkg::*;

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(offset))
        else $error("stalled result changed");

    // A failed push or pop leaves its sticky flag raised
    a_fail_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != ST_NO_SPACE || error_flags[FLAG_NO_SPACE])
                   && (status != ST_POP_BIG || error_flags[FLAG_POP_BIG]))
        else $error("failure status without sticky flag");

    // A nonzero offset only comes from a successful push that ends at or past it
    a_offset_push: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && offset != '0 |-> status == ST_OK && used_bytes >= offset)
        else $error("offset inconsistent with push result");

    // The low peak never climbs above zero
    a_low_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_low_peak[COUNT_WIDTH-1] || count_low_peak == '0)
        else $error("low peak above zero");

endmodule

bind stack_bump_allocator_core sba_checker #(
    .SPACE_WIDTH(SPACE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
) u_sba_checker (.*);
